[rtl/core/rlf_pkg.sv]
// Shared widths, controller states and command/status types for the LED fade ramp.
`default_nettype none
package rlf_pkg;

    localparam int LEVEL_W   = 8;
    localparam int TIME_W    = 16;
    localparam int CHANNELS  = 3;
    localparam int DIV_STEPS = TIME_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_COMMIT,
        ST_EMIT
    } rlf_state_t;

    typedef struct packed {
        logic tick;
        logic load;
        logic step;
        logic commit;
        logic emit;
    } rlf_cmd_t;

    typedef struct packed {
        logic out_free;
    } rlf_status_t;

endpackage
`default_nettype wire

[rtl/core/rlf_lane.sv]
// One color channel: fade state, tick update and an iterative 16-by-16 divider.
`default_nettype none
module rlf_lane
    import rlf_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rlf_cmd_t           cmd,
    input  wire logic [LEVEL_W-1:0] target_in,
    input  wire logic [TIME_W-1:0]  time_in,
    output logic [LEVEL_W-1:0]      level_out
);

    logic [LEVEL_W-1:0] tgt_reg,  tgt_next;
    logic [LEVEL_W-1:0] lvl_reg,  lvl_next;
    logic [LEVEL_W-1:0] step_reg, step_next;
    logic [LEVEL_W-1:0] wcnt_reg, wcnt_next;
    logic [LEVEL_W-1:0] wlim_reg, wlim_next;

    logic [LEVEL_W-1:0] pend_tgt_reg;
    logic               tz_reg, dz_reg, dgt_reg;
    logic [TIME_W-1:0]  rem_reg, quo_reg, dvs_reg;

    // load-time distance and operand selection
    logic [LEVEL_W-1:0] dist_abs;
    logic [TIME_W-1:0]  dist_w;
    logic               dist_gt;

    // one restoring division step
    logic [TIME_W:0]    shifted;
    logic [TIME_W:0]    diff;
    logic               fits;

    // tick move
    logic [LEVEL_W:0]   up_sum;
    logic [LEVEL_W-1:0] dn_diff;

    logic [LEVEL_W-1:0] quo_sat;

    always_comb begin
        dist_abs = (target_in > lvl_reg) ? target_in - lvl_reg : lvl_reg - target_in;
        dist_w   = {{(TIME_W-LEVEL_W){1'b0}}, dist_abs};
        dist_gt  = dist_w > time_in;

        shifted = {rem_reg, quo_reg[TIME_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};

        up_sum  = {1'b0, lvl_reg} + {1'b0, step_reg};
        dn_diff = lvl_reg - step_reg;

        quo_sat = (quo_reg[TIME_W-1:LEVEL_W] != '0) ? '1 : quo_reg[LEVEL_W-1:0];
    end

    always_comb begin
        tgt_next  = tgt_reg;
        lvl_next  = lvl_reg;
        step_next = step_reg;
        wcnt_next = wcnt_reg;
        wlim_next = wlim_reg;

        if (cmd.tick) begin
            if (wcnt_reg >= wlim_reg) begin
                if ({1'b0, tgt_reg} >= up_sum) begin
                    lvl_next = up_sum[LEVEL_W-1:0];
                end else if (lvl_reg >= step_reg && tgt_reg <= dn_diff) begin
                    lvl_next = dn_diff;
                end else begin
                    lvl_next = tgt_reg;
                end
                wcnt_next = '0;
            end else begin
                wcnt_next = wcnt_reg + 1'b1;
            end
        end

        if (cmd.commit) begin
            tgt_next = pend_tgt_reg;
            if (tz_reg) begin
                lvl_next  = pend_tgt_reg;
                step_next = LEVEL_W'(1);
                wlim_next = LEVEL_W'(1);
            end else if (dz_reg) begin
                step_next = LEVEL_W'(1);
                wlim_next = LEVEL_W'(1);
            end else if (dgt_reg) begin
                step_next = quo_reg[LEVEL_W-1:0];
                wlim_next = LEVEL_W'(1);
            end else begin
                step_next = LEVEL_W'(1);
                wlim_next = quo_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_reg  <= '0;
            lvl_reg  <= '0;
            step_reg <= '0;
            wcnt_reg <= '0;
            wlim_reg <= '0;
        end else begin
            tgt_reg  <= tgt_next;
            lvl_reg  <= lvl_next;
            step_reg <= step_next;
            wcnt_reg <= wcnt_next;
            wlim_reg <= wlim_next;
        end
    end

    // divider operands: larger of distance and time over the smaller
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pend_tgt_reg <= target_in;
            tz_reg       <= (time_in == '0);
            dz_reg       <= (dist_abs == '0);
            dgt_reg      <= dist_gt;
            rem_reg      <= '0;
            quo_reg      <= dist_gt ? dist_w : time_in;
            dvs_reg      <= dist_gt ? time_in : dist_w;
        end else if (cmd.step) begin
            rem_reg <= fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
            quo_reg <= {quo_reg[TIME_W-2:0], fits};
        end
    end

    assign level_out = lvl_reg;

endmodule
`default_nettype wire

[rtl/core/rlf_datapath.sv]
// Datapath: three channel lanes and the result register.
`default_nettype none
module rlf_datapath
    import rlf_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire rlf_cmd_t            cmd,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                m_tready,
    output logic                     m_tvalid,
    output logic [M_DATA_W-1:0]      m_tdata,
    output rlf_status_t              status
);

    logic [LEVEL_W-1:0]  level [CHANNELS];
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        rlf_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .target_in (s_tdata[c*LEVEL_W +: LEVEL_W]),
            .time_in   (s_tdata[CHANNELS*LEVEL_W +: TIME_W]),
            .level_out (level[c])
        );
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {level[2], level[1], level[0]};
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_data_reg;
    assign status.out_free = !m_valid_reg || m_tready;

endmodule
`default_nettype wire

[rtl/core/rlf_ctrl.sv]
// Controller: sequences tick, divider load, division steps, commit and result beat.
`default_nettype none
module rlf_ctrl
    import rlf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tuser,
    input  wire rlf_status_t status,
    output logic             s_tready,
    output rlf_cmd_t         cmd
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    rlf_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign accept = s_tvalid && (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    state_next = s_tuser ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.tick = accept && !s_tuser;
                cmd.load = accept && s_tuser;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/rgb_led_linear_fade_ramp_top.sv]
// Three-channel linear LED fade ramp: top level.
//
// Input stream (s_): each beat is a tick (s_tuser = 0) or a set (s_tuser = 1)
// carrying new red/green/blue targets and a shared fade time in ticks.
// Output stream (m_): one beat per input beat with the three levels after it.
// A set works out step size and wait limit per channel with three
// restoring dividers running side by side, one quotient bit per cycle.
// A tick goes on to load its result beat once the output is free; a set
// first runs the 16 divide steps and a commit, then loads its result. The next
// beat is accepted the cycle after the result is loaded, so no new beat is
// taken while one is in work; the 16-bit divide length sets the step count.
// A result register sits on the output: the block takes the next input
// while a result waits, and only stalls when a new result finds the
// register still full and m_tready low.
// Reset (aresetn low, synchronous) clears all levels, targets, steps,
// wait counters and limits to zero; ticks move nothing until a set.
`default_nettype none
module rgb_led_linear_fade_ramp_top
    import rlf_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [7:0] target_red, [15:8] target_green, [23:16] target_blue, [39:24] fade_time
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // [0] req_type
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [7:0] level_red, [15:8] level_green, [23:16] level_blue
    output logic [M_DATA_W-1:0]      m_tdata
);

    rlf_cmd_t    cmd;
    rlf_status_t status;

    rlf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    rlf_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .status   (status)
    );

endmodule
`default_nettype wire
